FILE: design/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants for the neighbor table with aging.
// ----------------------------------------------------------------------------
package nta_pkg;

  // Number of table slots. One slot is always kept free, so the table holds
  // at most TABLE_SLOTS-1 neighbors.
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = IDX_W;

  localparam int          BYTE_W          = 8;
  localparam int          INFO_BYTES      = 6;
  localparam int          INFO_W          = BYTE_W * INFO_BYTES;
  localparam int          TICK_W          = 32;
  localparam int          ID_W            = 16;
  localparam logic [31:0] AGE_LIMIT_RESET = 32'd64;

  // Configuration register map.
  localparam int         CFG_ADDR_W      = 3;
  localparam logic [0:0] REG_IDX_AGE_LIMIT = 1'b0;

  localparam logic MODE_RECEIVE = 1'b0;
  localparam logic MODE_PURGE   = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] now_tick;
    logic [7:0]        sender_chain;
    logic [7:0]        sender_gradient;
    logic [7:0]        sender_kind;
    logic [7:0]        sender_state;
    logic [7:0]        sender_neighbors;
    logic [7:0]        distance;
    logic [ID_W-1:0]   sender_id;
    logic              mode;
  } in_item_t;

  typedef struct packed {
    logic [3:0] removed;
    logic       dropped;
    logic       hit;
    logic [3:0] slot;
    logic [3:0] entry_count;
  } out_item_t;

  // One table entry as held in the RAM word.
  typedef struct packed {
    logic [INFO_W-1:0] info;
    logic [TICK_W-1:0] stamp;
    logic [ID_W-1:0]   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic idx_init_up;
    logic idx_init_down;
    logic idx_inc;
    logic idx_dec;
    logic rd_idx;
    logic rd_last;
    logic wr_item;
    logic wr_copy;
    logic cnt_inc;
    logic cnt_dec;
    logic rem_inc;
    logic set_hit;
    logic set_drop;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic purge;
    logic idx_at_cnt;
    logic idx_zero;
    logic id_match;
    logic stale;
    logic full;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: design/nta_ram.sv
// ----------------------------------------------------------------------------
// nta_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/nta_ctrl.sv
// ----------------------------------------------------------------------------
// nta_ctrl
// Sequencer for the neighbor table: walks the entries for a receive search
// or a purge scan and issues commands to the datapath.
// ----------------------------------------------------------------------------
module nta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nta_pkg::dp_sts_t    sts,
  output nta_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_RLOOK = 8'b0000_0100,
    S_RCMP  = 8'b0000_1000,
    S_PNEXT = 8'b0001_0000,
    S_PREAD = 8'b0010_0000,
    S_PCHK  = 8'b0100_0000,
    S_PCOPY = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   resp_r, resp_nxt;

  // The response step is kept as a separate flag so that any state can hand
  // over to it; while it is set the controller waits for the output register.
  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    in_ready  = 1'b0;

    if (resp_r) begin
      if (sts.out_free) begin
        cmd.load_out = 1'b1;
        resp_nxt     = 1'b0;
        state_nxt    = S_IDLE;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load_item = 1'b1;
            state_nxt     = S_START;
          end
        end
        S_START: begin
          if (sts.purge) begin
            cmd.idx_init_down = 1'b1;
            state_nxt         = S_PNEXT;
          end else begin
            cmd.idx_init_up = 1'b1;
            state_nxt       = S_RLOOK;
          end
        end
        S_RLOOK: begin
          if (sts.idx_at_cnt) begin
            if (sts.full) begin
              cmd.set_drop = 1'b1;
            end else begin
              cmd.wr_item = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
            resp_nxt = 1'b1;
          end else begin
            cmd.rd_idx = 1'b1;
            state_nxt  = S_RCMP;
          end
        end
        S_RCMP: begin
          if (sts.id_match) begin
            cmd.set_hit = 1'b1;
            cmd.wr_item = 1'b1;
            resp_nxt    = 1'b1;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RLOOK;
          end
        end
        S_PNEXT: begin
          if (sts.idx_zero) begin
            resp_nxt = 1'b1;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = S_PREAD;
          end
        end
        S_PREAD: begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_PCHK;
        end
        S_PCHK: begin
          if (sts.stale) begin
            cmd.rd_last = 1'b1;
            state_nxt   = S_PCOPY;
          end else begin
            state_nxt = S_PNEXT;
          end
        end
        S_PCOPY: begin
          cmd.wr_copy = 1'b1;
          cmd.cnt_dec = 1'b1;
          cmd.rem_inc = 1'b1;
          state_nxt   = S_PNEXT;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

FILE: design/nta_dp.sv
// ----------------------------------------------------------------------------
// nta_dp
// Datapath of the neighbor table: item register, scan index, entry count,
// entry RAM, age check and the result register.
// ----------------------------------------------------------------------------
module nta_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  nta_pkg::in_item_t   in_data,
  input  logic [31:0]         age_limit,
  input  nta_pkg::ctrl_cmd_t  cmd,
  output nta_pkg::dp_sts_t    sts,
  output logic                out_valid,
  input  logic                out_ready,
  output nta_pkg::out_item_t  out_data
);

  nta_pkg::in_item_t             item_r;
  logic [nta_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [nta_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [nta_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic                          hit_r, hit_nxt;
  logic                          drop_r, drop_nxt;
  logic                          out_valid_r, out_valid_nxt;
  nta_pkg::out_item_t            out_r;

  logic                          ram_we, ram_re;
  logic [nta_pkg::IDX_W-1:0]     ram_raddr;
  nta_pkg::entry_t               wr_entry, new_entry, rd_entry;
  logic [nta_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [nta_pkg::TICK_W-1:0]    age;
  logic [nta_pkg::CNT_W-1:0]     slot_val;
  logic [nta_pkg::CNT_W+3:0]     cnt_ext, slot_ext, rem_ext;

  assign new_entry.id    = item_r.sender_id;
  assign new_entry.stamp = item_r.now_tick;
  assign new_entry.info  = {item_r.sender_chain, item_r.sender_gradient, item_r.sender_kind,
                            item_r.sender_state, item_r.sender_neighbors, item_r.distance};

  assign ram_we    = cmd.wr_item | cmd.wr_copy;
  assign wr_entry  = cmd.wr_copy ? rd_entry : new_entry;
  assign ram_re    = cmd.rd_idx | cmd.rd_last;
  assign ram_raddr = cmd.rd_last ? (cnt_r - 1'b1) : idx_r;
  assign rd_entry  = nta_pkg::entry_t'(ram_rdata);

  nta_ram #(
    .WIDTH (nta_pkg::ENTRY_W),
    .DEPTH (nta_pkg::TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Modular tick difference; an entry is stale when it exceeds the limit.
  assign age = item_r.now_tick - rd_entry.stamp;

  assign sts.purge      = (item_r.mode == nta_pkg::MODE_PURGE);
  assign sts.idx_at_cnt = (idx_r == cnt_r);
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.id_match   = (rd_entry.id == item_r.sender_id);
  assign sts.stale      = (age > age_limit);
  assign sts.full       = (cnt_r == nta_pkg::CNT_W'(nta_pkg::TABLE_SLOTS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    hit_nxt  = hit_r;
    drop_nxt = drop_r;
    if (cmd.idx_init_up)   idx_nxt = '0;
    if (cmd.idx_init_down) idx_nxt = cnt_r;
    if (cmd.idx_inc)       idx_nxt = idx_r + 1'b1;
    if (cmd.idx_dec)       idx_nxt = idx_r - 1'b1;
    if (cmd.cnt_inc)       cnt_nxt = cnt_r + 1'b1;
    if (cmd.cnt_dec)       cnt_nxt = cnt_r - 1'b1;
    if (cmd.rem_inc)       rem_nxt = rem_r + 1'b1;
    if (cmd.set_hit)       hit_nxt = 1'b1;
    if (cmd.set_drop)      drop_nxt = 1'b1;
    if (cmd.load_item) begin
      rem_nxt  = '0;
      hit_nxt  = 1'b0;
      drop_nxt = 1'b0;
    end
  end

  // Result fields are four bits wide; narrower counts are zero-extended.
  assign slot_val = (sts.purge || drop_r) ? '0 : idx_r;
  assign cnt_ext  = {4'b0, cnt_r};
  assign slot_ext = {4'b0, slot_val};
  assign rem_ext  = {4'b0, rem_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    hit_r  <= hit_nxt;
    drop_r <= drop_nxt;
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r.entry_count <= cnt_ext[3:0];
      out_r.slot        <= slot_ext[3:0];
      out_r.hit         <= hit_r;
      out_r.dropped     <= drop_r;
      out_r.removed     <= rem_ext[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/neighbor_table_with_aging.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Table of radio neighbors keyed by sender ID, with timeout eviction.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_ready     nta_pkg::in_item_t
//   out_     output     out_valid / out_ready   nta_pkg::out_item_t
//   cfg_     input      APB write/read          age_limit at byte address 0
//
// A receive item walks the entries until it finds its sender ID or reaches the count;
// a purge item walks every entry and copies the last entry over each removed one.
// The single registered read port of the entry RAM sets the pace of both walks:
// a search spends two sequencer steps per entry, a purge three (step, read, check)
// and one more copy step for each removed entry.
// Reset clears the entry count and restores age_limit to 64; the entry RAM itself is
// not cleared, since only entries below the count are ever read.
// The result sits in an output register, so a new item is taken while the previous
// result still waits for out_ready; that item then stalls until the register frees.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  nta_pkg::in_item_t                  in_data,

  output logic                               out_valid,
  input  logic                               out_ready,
  output nta_pkg::out_item_t                 out_data,

  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [nta_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  nta_pkg::ctrl_cmd_t cmd;
  nta_pkg::dp_sts_t   sts;

  logic [31:0] age_limit_r, age_limit_nxt;
  logic        cfg_wr;
  logic        cfg_sel_age;

  // The register index is the word address; there is one register, so only
  // word 0 holds storage and other words read as zero.
  assign cfg_sel_age = (cfg_paddr[2] == nta_pkg::REG_IDX_AGE_LIMIT);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = cfg_sel_age ? age_limit_r : 32'd0;

  always_comb begin
    age_limit_nxt = age_limit_r;
    if (cfg_wr && cfg_sel_age) begin
      age_limit_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= nta_pkg::AGE_LIMIT_RESET;
    end else begin
      age_limit_r <= age_limit_nxt;
    end
  end

  // The controller steps through the search or the purge scan; the datapath
  // holds the item, the counters, the entry RAM and the result register.
  nta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nta_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .age_limit (age_limit_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/neighbor_table_checker.sv
// ----------------------------------------------------------------------------
// neighbor_table_checker
// Watches the item, result and configuration ports of the neighbor table,
// keeps its own copy of the table and compares every result transfer with
// the oldest predicted result.
// ----------------------------------------------------------------------------
module neighbor_table_checker
  import nta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic [31:0]           cfg_prdata,
  input  logic                  cfg_pready,

  output int                    fail_count,
  output int                    pending
);

  localparam logic [CFG_ADDR_W-1:0] AGE_LIMIT_ADDR = {REG_IDX_AGE_LIMIT, 2'b00};

  // Shadow of the neighbor table.
  logic [ID_W-1:0]   nbr_id    [TABLE_SLOTS];
  logic [TICK_W-1:0] nbr_stamp [TABLE_SLOTS];
  logic [INFO_W-1:0] nbr_info  [TABLE_SLOTS];
  int unsigned       nbr_count = 0;
  logic [31:0]       age_limit = AGE_LIMIT_RESET;

  out_item_t         result_q[$];
  int                errors = 0;

  // Applies one item to the shadow table and returns the result it causes.
  function automatic out_item_t update_table(input in_item_t it);
    out_item_t         r;
    int unsigned       i;
    int unsigned       last;
    int unsigned       removed;
    logic              found;
    logic [TICK_W-1:0] age;
    r       = '0;
    removed = 0;
    if (nbr_count > TABLE_SLOTS - 1) nbr_count = TABLE_SLOTS - 1;
    if (it.mode == MODE_RECEIVE) begin
      found = 1'b0;
      i     = 0;
      while (i < nbr_count && !found) begin
        if (nbr_id[i] == it.sender_id) found = 1'b1;
        else i++;
      end
      if (found) begin
        r.hit = 1'b1;
      end else if (nbr_count < TABLE_SLOTS - 1) begin
        nbr_count++;
      end else begin
        r.dropped = 1'b1;
      end
      if (!r.dropped) begin
        r.slot       = i[3:0];
        nbr_id[i]    = it.sender_id;
        nbr_stamp[i] = it.now_tick;
        nbr_info[i]  = {it.sender_chain, it.sender_gradient, it.sender_kind,
                        it.sender_state, it.sender_neighbors, it.distance};
      end
    end else begin
      i = nbr_count;
      while (i > 0) begin
        i--;
        age = it.now_tick - nbr_stamp[i];
        if (age > age_limit) begin
          last         = nbr_count - 1;
          nbr_id[i]    = nbr_id[last];
          nbr_stamp[i] = nbr_stamp[last];
          nbr_info[i]  = nbr_info[last];
          nbr_count    = last;
          removed++;
        end
      end
    end
    r.entry_count = nbr_count[3:0];
    r.removed     = removed[3:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      nbr_count = 0;
      age_limit = AGE_LIMIT_RESET;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, expected none, actual %p",
                   $time, out_data);
        end else begin
          want = result_q.pop_front();
          check_field("entry_count", want.entry_count, out_data.entry_count);
          check_field("slot", want.slot, out_data.slot);
          check_field("hit", want.hit, out_data.hit);
          check_field("dropped", want.dropped, out_data.dropped);
          check_field("removed", want.removed, out_data.removed);
        end
      end
      if (in_valid && in_ready) result_q.push_back(update_table(in_data));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == AGE_LIMIT_ADDR) begin
        if (cfg_pwrite) age_limit = cfg_pwdata;
        else check_field("age_limit readback", age_limit, cfg_prdata);
      end
    end
    fail_count <= errors;
    pending    <= result_q.size();
  end

endmodule

FILE: tb/neighbor_table_with_aging_test.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_test
// Drives receive and purge items into the neighbor table under several age
// limits, with random idling on both channels, and reports the verdict that
// the checker's failure count gives.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_test;
  import nta_pkg::*;

  // The slowest item is a purge of a full table that removes every entry.
  // The long receiver hold-off dominates the limit.
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SETTLE_CYCLES    = 80;
  localparam int PHASE_ITEMS      = 110;

  localparam logic [CFG_ADDR_W-1:0] AGE_LIMIT_ADDR = {REG_IDX_AGE_LIMIT, 2'b00};

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int                    fail_count;
  int                    pending;

  // Stimulus control shared with the receiver process.
  logic                  idle_on    = 1'b1;
  int                    hold_seq   = 0;
  int                    hold_seen  = 0;
  int                    hold_left  = 0;
  int                    ready_gap  = 0;
  int                    stall_cycles = 0;

  // Running tick and the base of the ID pool of the current phase.
  logic [TICK_W-1:0]     tick_now   = '0;
  logic [ID_W-1:0]       id_base    = '0;

  neighbor_table_with_aging u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  neighbor_table_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result receiver. A request from the stimulus process starts a long
  // hold-off that this process counts on its own; otherwise out_ready drops
  // for random bursts while idling is enabled.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      ready_gap <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any cycle without a transfer on some port counts toward the
  // limit, and a transfer restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Builds an item with random neighbor info bytes.
  function automatic in_item_t make_item(input logic mode, input logic [ID_W-1:0] id,
                                         input logic [TICK_W-1:0] tick);
    in_item_t it;
    it.mode             = mode;
    it.sender_id        = id;
    it.distance         = $urandom;
    it.sender_neighbors = $urandom;
    it.sender_state     = $urandom;
    it.sender_kind      = $urandom;
    it.sender_gradient  = $urandom;
    it.sender_chain     = $urandom;
    it.now_tick         = tick;
    return it;
  endfunction

  // Offers one item and returns at the edge where its transfer happens.
  // Valid stays high from one item to the next unless an idle burst is drawn.
  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One APB access to the age limit register: setup cycle, then access.
  task automatic cfg_access(input logic write, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= AGE_LIMIT_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Waits until every predicted result has been transferred, then lets the
  // block settle. The first edge is taken before the test so that the
  // checker's count already includes the last item transfer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    in_item_t it;
    // Purge of an empty table.
    send_item(make_item(MODE_PURGE, 16'h0000, 32'h0000_0000));
    // Lowest ID with all info bytes zero, then highest ID with all ones at the
    // last tick before the wrap.
    it = make_item(MODE_RECEIVE, 16'h0000, 32'h0000_0000);
    {it.distance, it.sender_neighbors, it.sender_state,
     it.sender_kind, it.sender_gradient, it.sender_chain} = '0;
    send_item(it);
    it = make_item(MODE_RECEIVE, 16'hFFFF, 32'hFFFF_FFFF);
    {it.distance, it.sender_neighbors, it.sender_state,
     it.sender_kind, it.sender_gradient, it.sender_chain} = '1;
    send_item(it);
    // A repeat of a known ID is a hit on its slot.
    send_item(make_item(MODE_RECEIVE, 16'h0000, 32'h0000_0000));
    // Fill the table to its capacity of TABLE_SLOTS-1 entries.
    for (int k = 1; k <= TABLE_SLOTS - 3; k++) begin
      send_item(make_item(MODE_RECEIVE, k[ID_W-1:0], 32'h0000_0000));
    end
    // A new sender on a full table is dropped, a known one still hits.
    send_item(make_item(MODE_RECEIVE, 16'h1234, 32'h0000_0000));
    send_item(make_item(MODE_RECEIVE, 16'h0007, 32'h0000_0000));
    // Age of exactly the limit survives; the entry stamped just before the
    // tick wrap is 65 ticks old and goes.
    send_item(make_item(MODE_PURGE, 16'h0000, AGE_LIMIT_RESET));
    send_item(make_item(MODE_RECEIVE, 16'h00FF, 32'h0000_0000));
    // Every entry is stale: fifteen removals in one purge.
    send_item(make_item(MODE_PURGE, 16'hFFFF, 32'd200));
    // A stamp that lies in the future looks very old.
    send_item(make_item(MODE_RECEIVE, 16'h0005, 32'd1000));
    send_item(make_item(MODE_PURGE, 16'h0000, 32'd500));
  endtask

  // One phase of random traffic. Most items come from a small pool of IDs so
  // that hits, appends, drops and aging all happen; a few use any ID or the
  // extreme IDs. The tick advances by a random step up to step_max, a purge
  // comes about every sixth item, and now and then an item carries an older
  // tick so that stamps end up in the future.
  task automatic run_phase(input logic do_write, input logic [31:0] limit,
                           input logic [31:0] step_max, input logic hold);
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] tick;
    logic              mode;
    int                pick;
    if (do_write) begin
      cfg_access(1'b1, limit);
      cfg_access(1'b0, '0);
    end
    id_base = $urandom;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (hold && k == 40) hold_seq <= hold_seq + 1;
      pick = $urandom_range(0, 19);
      if (pick < 14) id = id_base + $urandom_range(0, 19);
      else if (pick < 17) id = $urandom;
      else id = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      if (step_max == '1) tick_now = tick_now + $urandom;
      else tick_now = tick_now + $urandom_range(0, step_max);
      tick = tick_now;
      if ($urandom_range(0, 24) == 0) tick = tick_now - $urandom_range(1, 500);
      mode = ($urandom_range(0, 5) == 0) ? MODE_PURGE : MODE_RECEIVE;
      send_item(make_item(mode, id, tick));
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The reset value of the age limit reads back before any write.
    cfg_access(1'b0, '0);
    run_directed();
    wait_drained();

    // Reset limit, with the long receiver hold-off in the middle.
    run_phase(1'b0, AGE_LIMIT_RESET, 32'd12, 1'b1);
    // Zero limit: only entries stamped at the current tick survive.
    run_phase(1'b1, 32'h0000_0000, 32'd2, 1'b0);
    // Largest limit: nothing ever ages out, ticks span the full range.
    run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    run_phase(1'b1, 32'd5, 32'd3, 1'b0);
    // Start just below the wrap so the tick rolls over during the phase.
    tick_now = 32'hFFFF_FF00;
    run_phase(1'b1, 32'd300, 32'd40, 1'b0);
    run_phase(1'b1, $urandom, 32'hFFFF_FFFF, 1'b0);
    // Last part of the run without any idling.
    idle_on <= 1'b0;
    run_phase(1'b1, AGE_LIMIT_RESET, 32'd12, 1'b0);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
